@@ rtl/superblock_qp_rate_control_assert.svh @@
// Assertion macros for the superblock QP rate controller.
// Used by the port checker; each macro expects clk and rst_n in scope.
`ifndef SUPERBLOCK_QP_RATE_CONTROL_ASSERT_SVH
`define SUPERBLOCK_QP_RATE_CONTROL_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SBQP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rate control check failed");

// The consequent must hold in the cycle after the antecedent.
`define SBQP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rate control check failed");

`endif

@@ rtl/sbqp_pkg.sv @@
// Shared types, widths, codes and lookup tables for the superblock QP rate controller.
// No dependencies; the other design modules refer to it by scoped names, the sim files import it.
`default_nettype none

package sbqp_pkg;

    // Default depth of the per-superblock history store.
    localparam int MAX_SUPERBLOCKS_DEF = 4096;
    // Largest quantiser step size that the tables cover.
    localparam int MAX_STEP = 228;
    localparam int TOP_QP   = 51;

    // Field and register widths.
    localparam int FUNC_W     = 2;
    localparam int IDX_W      = 12;
    localparam int BITS_W     = 20;
    localparam int QP_W       = 6;
    localparam int FBITS_W    = 28;
    localparam int TB_W       = 24;
    localparam int NSB_W      = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int STEP_W     = 8;
    localparam int WIN_W      = 40;
    localparam int OV_W       = 48;
    localparam int BUF_W      = 32;
    localparam int CF_W       = 32;
    localparam int TGT_W      = 41;
    // A stored bit count can be a whole start estimate, so it keeps the target's width.
    localparam int EBITS_W    = TB_W;
    localparam int ENTRY_W    = EBITS_W + QP_W;

    // Shared serial divider.
    localparam int DIV_W     = 48;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    localparam logic [CF_W-1:0] CF_RESET = 32'd256;

    // Item function codes.
    localparam logic [FUNC_W-1:0] FUNC_SB        = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FRAME_END = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_START     = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_BITS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_SUPERBLOCKS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_QP          = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_QP          = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INTRA_FLOOR_QP  = 3'd4;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_SB_RD,
        S_SB_UPD,
        S_SB_DIV_GO,
        S_SB_DIV_WAIT,
        S_SB_OUT,
        S_FE_LVL,
        S_FE_CF_GO,
        S_FE_CF_WAIT,
        S_ST_BPS_GO,
        S_ST_BPS_WAIT,
        S_ST_STEP_GO,
        S_ST_STEP_WAIT,
        S_ST_INIT,
        S_ST_FILL
    } state_t;

    // Divider request and status.
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

    // Step size for each QP: 2^((QP-4)/6).
    localparam logic [STEP_W-1:0] STEP_OF_QP [0:51] = '{
        8'd0, 8'd0, 8'd0, 8'd0, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd2, 8'd2, 8'd2,
        8'd2, 8'd3, 8'd3, 8'd4, 8'd4, 8'd5, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9, 8'd10, 8'd11,
        8'd12, 8'd14, 8'd16, 8'd18, 8'd20, 8'd22, 8'd25, 8'd28, 8'd32, 8'd36, 8'd40,
        8'd45, 8'd51, 8'd57, 8'd64, 8'd72, 8'd80, 8'd90, 8'd102, 8'd114, 8'd128,
        8'd144, 8'd160, 8'd180, 8'd204, 8'd228
    };

    // QP for each step size: 6*log2(step)+4.
    localparam logic [QP_W-1:0] QP_OF_STEP [0:228] = '{
        6'd0, 6'd4, 6'd10, 6'd14, 6'd16, 6'd18, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
        6'd26, 6'd26, 6'd27, 6'd27, 6'd28, 6'd29, 6'd29, 6'd29, 6'd30, 6'd30, 6'd31,
        6'd31, 6'd32, 6'd32, 6'd32, 6'd33, 6'd33, 6'd33, 6'd33, 6'd34, 6'd34, 6'd34,
        6'd35, 6'd35, 6'd35, 6'd35, 6'd35, 6'd36, 6'd36, 6'd36, 6'd36, 6'd37, 6'd37,
        6'd37, 6'd37, 6'd37, 6'd38, 6'd38, 6'd38, 6'd38, 6'd38, 6'd38, 6'd39, 6'd39,
        6'd39, 6'd39, 6'd39, 6'd39, 6'd39, 6'd40, 6'd40, 6'd40, 6'd40, 6'd40, 6'd40,
        6'd40, 6'd41, 6'd41, 6'd41, 6'd41, 6'd41, 6'd41, 6'd41, 6'd41, 6'd41, 6'd42,
        6'd42, 6'd42, 6'd42, 6'd42, 6'd42, 6'd42, 6'd42, 6'd42, 6'd43, 6'd43, 6'd43,
        6'd43, 6'd43, 6'd43, 6'd43, 6'd43, 6'd43, 6'd43, 6'd44, 6'd44, 6'd44, 6'd44,
        6'd44, 6'd44, 6'd44, 6'd44, 6'd44, 6'd44, 6'd44, 6'd44, 6'd45, 6'd45, 6'd45,
        6'd45, 6'd45, 6'd45, 6'd45, 6'd45, 6'd45, 6'd45, 6'd45, 6'd45, 6'd45, 6'd46,
        6'd46, 6'd46, 6'd46, 6'd46, 6'd46, 6'd46, 6'd46, 6'd46, 6'd46, 6'd46, 6'd46,
        6'd46, 6'd46, 6'd46, 6'd47, 6'd47, 6'd47, 6'd47, 6'd47, 6'd47, 6'd47, 6'd47,
        6'd47, 6'd47, 6'd47, 6'd47, 6'd47, 6'd47, 6'd47, 6'd47, 6'd47, 6'd48, 6'd48,
        6'd48, 6'd48, 6'd48, 6'd48, 6'd48, 6'd48, 6'd48, 6'd48, 6'd48, 6'd48, 6'd48,
        6'd48, 6'd48, 6'd48, 6'd48, 6'd48, 6'd49, 6'd49, 6'd49, 6'd49, 6'd49, 6'd49,
        6'd49, 6'd49, 6'd49, 6'd49, 6'd49, 6'd49, 6'd49, 6'd49, 6'd49, 6'd49, 6'd49,
        6'd49, 6'd49, 6'd49, 6'd49, 6'd50, 6'd50, 6'd50, 6'd50, 6'd50, 6'd50, 6'd50,
        6'd50, 6'd50, 6'd50, 6'd50, 6'd50, 6'd50, 6'd50, 6'd50, 6'd50, 6'd50, 6'd50,
        6'd50, 6'd50, 6'd50, 6'd50, 6'd50, 6'd50, 6'd51, 6'd51, 6'd51, 6'd51, 6'd51,
        6'd51, 6'd51, 6'd51, 6'd51, 6'd51, 6'd51, 6'd51, 6'd51
    };

    // Limit a quotient to the largest step in the table.
    function automatic logic [STEP_W-1:0] step_cap(input logic [DIV_W-1:0] q);
        logic [STEP_W-1:0] s;
        if (q > DIV_W'(MAX_STEP))
        begin
            s = STEP_W'(MAX_STEP);
        end
        else
        begin
            s = q[STEP_W-1:0];
        end
        return s;
    endfunction

    // Saturate a QP value to the top of the table.
    function automatic logic [QP_W-1:0] qp_cap(input logic [QP_W-1:0] q);
        return (q > QP_W'(TOP_QP)) ? QP_W'(TOP_QP) : q;
    endfunction

endpackage

`default_nettype wire

@@ rtl/sbqp_mem.sv @@
// Per-superblock history store: last bit count and QP, one entry per superblock.
// Synchronous write and registered read; uses sbqp_pkg for the entry width.
`default_nettype none

module sbqp_mem #(
    parameter int DEPTH = sbqp_pkg::MAX_SUPERBLOCKS_DEF,
    parameter int AW    = 12
) (
    input  wire logic                         clk,
    input  wire logic                         we,
    input  wire logic [AW-1:0]                waddr,
    input  wire logic [sbqp_pkg::ENTRY_W-1:0] wdata,
    input  wire logic [AW-1:0]                raddr,
    output logic      [sbqp_pkg::ENTRY_W-1:0] rdata
);

    logic [sbqp_pkg::ENTRY_W-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/sbqp_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
// Uses the request and status structs of sbqp_pkg.
`default_nettype none

module sbqp_div (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire sbqp_pkg::div_req_t req,
    output sbqp_pkg::div_sts_t      sts,
    output logic [sbqp_pkg::DIV_W-1:0] quo
);

    localparam int W = sbqp_pkg::DIV_W;

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [sbqp_pkg::DIV_CNT_W-1:0]    cnt_reg, cnt_next;
    logic [W-1:0]                      rem_reg, rem_next;
    logic [W-1:0]                      quo_reg, quo_next;
    logic [W-1:0]                      den_reg, den_next;
    logic [W:0]                        shifted;
    logic                              ge;

    // One step of the shift-and-subtract recurrence.
    assign shifted = {rem_reg, quo_reg[W-1]};
    assign ge      = (shifted >= {1'b0, den_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = sbqp_pkg::DIV_CNT_W'(W);
            rem_next  = '0;
            quo_next  = req.num;
            den_next  = req.den;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? W'(shifted - {1'b0, den_reg}) : shifted[W-1:0];
            quo_next = {quo_reg[W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == sbqp_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operand and partial result registers.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign quo      = quo_reg;

endmodule

`default_nettype wire

@@ rtl/superblock_qp_rate_control.sv @@
// Top level of the superblock QP rate controller: sequencer, datapath and output register.
// Instantiates sbqp_mem and sbqp_div; uses sbqp_pkg.
`default_nettype none

// The block takes one item at a time and holds item_stall high while it works on it.
// A superblock item with an index in range reads its history entry, updates the window
// and overproduction sums and runs one 48-bit serial divide for its QP beat. A frame-end
// item takes its correction factor from the same divider, and runs no divide when
// frame_bits is zero. A start item runs two divides and then writes the history store
// one entry per cycle, min(num_superblocks, MAX_SUPERBLOCKS) entries in all. The
// history store has no reset; entries not written since reset read as garbage. A
// finished QP waits in an output register, so the next item can be taken while it is
// still stalled.
module superblock_qp_rate_control #(
    parameter int MAX_SUPERBLOCKS = sbqp_pkg::MAX_SUPERBLOCKS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [sbqp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [sbqp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                            item_valid,
    output logic                                 item_stall,
    input  wire logic [sbqp_pkg::FUNC_W-1:0]     func,
    input  wire logic [sbqp_pkg::IDX_W-1:0]      sb_index,
    input  wire logic [sbqp_pkg::BITS_W-1:0]     sb_bits,
    input  wire logic [sbqp_pkg::QP_W-1:0]       sb_qp,
    input  wire logic [sbqp_pkg::FBITS_W-1:0]    frame_bits,
    output logic                                 result_valid,
    input  wire logic                            result_stall,
    output logic [sbqp_pkg::QP_W-1:0]            next_qp
);

    localparam int SB_AW = (MAX_SUPERBLOCKS > 1) ? $clog2(MAX_SUPERBLOCKS) : 1;
    localparam int CNT_W = $clog2(MAX_SUPERBLOCKS + 1);
    localparam int EXT_W = SB_AW + sbqp_pkg::IDX_W;
    localparam int TB_W  = sbqp_pkg::TB_W;
    localparam int QP_W  = sbqp_pkg::QP_W;
    localparam int DW    = sbqp_pkg::DIV_W;

    // Configuration registers.
    logic [TB_W-1:0]            target_reg;
    logic [sbqp_pkg::NSB_W-1:0] num_sb_reg;
    logic [QP_W-1:0]            min_qp_reg;
    logic [QP_W-1:0]            max_qp_reg;
    logic [QP_W-1:0]            floor_qp_reg;

    // Sequencer.
    sbqp_pkg::state_t state_reg, state_next;
    logic             accept;
    logic             idx_ok;
    logic             out_load;

    // Latched item fields.
    logic [SB_AW-1:0]             addr_reg;
    logic [sbqp_pkg::BITS_W-1:0]  bits_reg;
    logic [QP_W-1:0]              qp_reg;
    logic [sbqp_pkg::FBITS_W-1:0] fbits_reg;
    logic [EXT_W-1:0]             idx_ext;

    // Rate control state.
    logic [sbqp_pkg::WIN_W-1:0] window_reg, window_next;
    logic [sbqp_pkg::WIN_W-1:0] frame_reg, frame_next;
    logic [sbqp_pkg::BUF_W-1:0] buf_reg, buf_next;
    logic [TB_W-1:0]            init_reg, init_next;
    logic [sbqp_pkg::OV_W-1:0]  ov_reg, ov_next;
    logic [sbqp_pkg::CF_W-1:0]  cf_reg, cf_next;

    // Intermediate results.
    logic [27:0]                 cur_reg;
    logic [31:0]                 last_reg;
    logic [55:0]                 cfp_reg;
    logic [sbqp_pkg::TGT_W-1:0]  tgt_reg, tgt_next;
    logic [QP_W-1:0]             nq_reg, nq_next;
    logic [TB_W-1:0]             bps_reg, bps_next;
    logic [QP_W-1:0]             qp0_reg, qp0_next;
    logic [CNT_W-1:0]            fill_cnt_reg, fill_cnt_next;
    logic [CNT_W-1:0]            fill_len;
    logic                        fill_more;

    // Output register.
    logic            result_valid_reg;
    logic [QP_W-1:0] next_qp_reg;

    // Memory and divider connections.
    logic                         mem_we;
    logic [SB_AW-1:0]             mem_waddr;
    logic [sbqp_pkg::ENTRY_W-1:0] mem_wdata;
    logic [sbqp_pkg::ENTRY_W-1:0] mem_rdata;
    logic [TB_W-1:0]              rd_bits;
    logic [QP_W-1:0]              rd_qp;
    sbqp_pkg::div_req_t           div_req;
    sbqp_pkg::div_sts_t           div_sts;
    logic [DW-1:0]                div_quo;

    // Datapath arithmetic.
    logic signed [41:0]  win_sum;
    logic signed [41:0]  frm_sum;
    logic signed [57:0]  ov_sum;
    logic signed [48:0]  ov_rnd;
    logic signed [42:0]  tgt_raw;
    logic signed [43:0]  sb_num;
    logic [DW-1:0]       sb_div_num;
    logic signed [34:0]  lvl;
    logic signed [33:0]  buf_diff;
    logic [32:0]         cf_num;
    logic [sbqp_pkg::NSB_W-1:0] nsb;
    logic [TB_W-1:0]     bps_den;
    logic [sbqp_pkg::STEP_W-1:0] sb_step;
    logic [sbqp_pkg::STEP_W-1:0] st_step;
    logic [QP_W-1:0]     sb_qp_tab;
    logic [QP_W-1:0]     st_qp_tab;
    logic [QP_W-1:0]     st_qp_floor;
    logic [QP_W-1:0]     nq_hi;

    assign accept  = item_valid && !item_stall;
    assign idx_ext = EXT_W'(sb_index);
    assign idx_ok  = (32'(sb_index) < 32'(MAX_SUPERBLOCKS));

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg   <= 24'd100000;
            num_sb_reg   <= 13'd1;
            min_qp_reg   <= '0;
            max_qp_reg   <= QP_W'(sbqp_pkg::TOP_QP);
            floor_qp_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sbqp_pkg::CFG_TARGET_BITS:     target_reg   <= cfg_data;
                sbqp_pkg::CFG_NUM_SUPERBLOCKS: num_sb_reg   <= cfg_data[sbqp_pkg::NSB_W-1:0];
                sbqp_pkg::CFG_MIN_QP:          min_qp_reg   <= cfg_data[QP_W-1:0];
                sbqp_pkg::CFG_MAX_QP:          max_qp_reg   <= cfg_data[QP_W-1:0];
                sbqp_pkg::CFG_INTRA_FLOOR_QP:  floor_qp_reg <= cfg_data[QP_W-1:0];
                default:                       ;
            endcase
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sbqp_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (func == sbqp_pkg::FUNC_START)
                    begin
                        state_next = sbqp_pkg::S_ST_BPS_GO;
                    end
                    else if (func == sbqp_pkg::FUNC_FRAME_END)
                    begin
                        state_next = sbqp_pkg::S_FE_LVL;
                    end
                    else if (func == sbqp_pkg::FUNC_SB && idx_ok)
                    begin
                        state_next = sbqp_pkg::S_SB_RD;
                    end
                end
            end
            sbqp_pkg::S_SB_RD:       state_next = sbqp_pkg::S_SB_UPD;
            sbqp_pkg::S_SB_UPD:      state_next = sbqp_pkg::S_SB_DIV_GO;
            sbqp_pkg::S_SB_DIV_GO:   state_next = sbqp_pkg::S_SB_DIV_WAIT;
            sbqp_pkg::S_SB_DIV_WAIT:
            begin
                if (div_sts.done)
                begin
                    state_next = sbqp_pkg::S_SB_OUT;
                end
            end
            sbqp_pkg::S_SB_OUT:
            begin
                if (out_load)
                begin
                    state_next = sbqp_pkg::S_IDLE;
                end
            end
            sbqp_pkg::S_FE_LVL:      state_next = sbqp_pkg::S_FE_CF_GO;
            sbqp_pkg::S_FE_CF_GO:
            begin
                state_next = (fbits_reg == '0) ? sbqp_pkg::S_IDLE : sbqp_pkg::S_FE_CF_WAIT;
            end
            sbqp_pkg::S_FE_CF_WAIT:
            begin
                if (div_sts.done)
                begin
                    state_next = sbqp_pkg::S_IDLE;
                end
            end
            sbqp_pkg::S_ST_BPS_GO:   state_next = sbqp_pkg::S_ST_BPS_WAIT;
            sbqp_pkg::S_ST_BPS_WAIT:
            begin
                if (div_sts.done)
                begin
                    state_next = sbqp_pkg::S_ST_STEP_GO;
                end
            end
            sbqp_pkg::S_ST_STEP_GO:  state_next = sbqp_pkg::S_ST_STEP_WAIT;
            sbqp_pkg::S_ST_STEP_WAIT:
            begin
                if (div_sts.done)
                begin
                    state_next = sbqp_pkg::S_ST_INIT;
                end
            end
            sbqp_pkg::S_ST_INIT:     state_next = sbqp_pkg::S_ST_FILL;
            sbqp_pkg::S_ST_FILL:
            begin
                if (!fill_more)
                begin
                    state_next = sbqp_pkg::S_IDLE;
                end
            end
            default:                 state_next = sbqp_pkg::S_IDLE;
        endcase
    end

    // Sequencer outputs: handshake, memory write and divider requests.
    always_comb
    begin
        item_stall  = (state_reg != sbqp_pkg::S_IDLE);
        out_load    = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = addr_reg;
        mem_wdata   = {4'd0, bits_reg, qp_reg};
        div_req     = '0;
        case (state_reg)
            sbqp_pkg::S_SB_RD:
            begin
                mem_we = 1'b1;
            end
            sbqp_pkg::S_SB_DIV_GO:
            begin
                div_req.start = 1'b1;
                div_req.num   = sb_div_num;
                div_req.den   = DW'(tgt_reg);
            end
            sbqp_pkg::S_SB_OUT:
            begin
                out_load = !result_valid_reg || !result_stall;
            end
            sbqp_pkg::S_FE_CF_GO:
            begin
                div_req.start = (fbits_reg != '0);
                div_req.num   = DW'(cf_num);
                div_req.den   = DW'(fbits_reg);
            end
            sbqp_pkg::S_ST_BPS_GO:
            begin
                div_req.start = 1'b1;
                div_req.num   = DW'(target_reg);
                div_req.den   = DW'(nsb);
            end
            sbqp_pkg::S_ST_STEP_GO:
            begin
                div_req.start = 1'b1;
                div_req.num   = DW'(2048);
                div_req.den   = DW'(bps_den);
            end
            sbqp_pkg::S_ST_FILL:
            begin
                mem_we    = fill_more;
                mem_waddr = fill_cnt_reg[SB_AW-1:0];
                mem_wdata = {bps_reg, qp0_reg};
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    // Superblock update: window and frame sums, bit target and overproduction.
    assign win_sum = $signed({{2{window_reg[39]}}, window_reg})
                   + $signed({14'd0, cur_reg}) - $signed({10'd0, last_reg});
    assign frm_sum = $signed({{2{frame_reg[39]}}, frame_reg}) + $signed({14'd0, cur_reg});
    assign ov_sum  = $signed({{10{ov_reg[47]}}, ov_reg})
                   + $signed({30'd0, bits_reg, 8'd0}) - $signed({2'd0, cfp_reg});
    assign ov_rnd  = $signed({ov_reg[47], ov_reg}) + 49'sd128;
    assign tgt_raw = $signed({19'd0, target_reg}) - $signed({{2{ov_rnd[48]}}, ov_rnd[48:8]});

    // Rounded numerator for the step size divide; a nonpositive one gives a zero quotient, raised to step one.
    assign sb_num     = $signed({{4{window_reg[39]}}, window_reg}) + $signed({4'd0, tgt_reg[40:1]});
    assign sb_div_num = (sb_num[43] || (sb_num == '0)) ? '0 : {4'd0, sb_num[43:0]};

    // Step size to QP, then the frame's QP limits with the minimum applied last.
    assign sb_step   = (sbqp_pkg::step_cap(div_quo) == '0) ? 8'd1 : sbqp_pkg::step_cap(div_quo);
    assign sb_qp_tab = sbqp_pkg::QP_OF_STEP[sb_step];
    assign nq_hi     = (sb_qp_tab > max_qp_reg) ? max_qp_reg : sb_qp_tab;

    // Frame end: buffer level and correction factor numerator.
    assign lvl      = $signed({3'd0, buf_reg}) + $signed({7'd0, fbits_reg})
                    - $signed({11'd0, target_reg});
    assign buf_diff = $signed({2'd0, buf_reg}) - $signed({10'd0, init_reg});
    assign cf_num   = {1'b0, target_reg, 8'd0} + {6'd0, fbits_reg[27:1]};

    // Start: bits per superblock and the initial QP estimate.
    assign nsb         = (num_sb_reg == '0) ? sbqp_pkg::NSB_W'(1) : num_sb_reg;
    assign bps_den     = (bps_reg == '0) ? TB_W'(1) : bps_reg;
    assign st_step     = sbqp_pkg::step_cap(div_quo);
    assign st_qp_tab   = sbqp_pkg::QP_OF_STEP[st_step];
    assign st_qp_floor = (floor_qp_reg > st_qp_tab) ? floor_qp_reg : st_qp_tab;

    // History fill length and progress.
    assign fill_len  = (32'(num_sb_reg) < 32'(MAX_SUPERBLOCKS)) ? CNT_W'(num_sb_reg)
                                                                 : CNT_W'(MAX_SUPERBLOCKS);
    assign fill_more = (fill_cnt_reg < fill_len);

    assign rd_bits = mem_rdata[sbqp_pkg::ENTRY_W-1:QP_W];
    assign rd_qp   = sbqp_pkg::qp_cap(mem_rdata[QP_W-1:0]);

    // Next values of the rate control state.
    always_comb
    begin
        window_next   = window_reg;
        frame_next    = frame_reg;
        buf_next      = buf_reg;
        init_next     = init_reg;
        ov_next       = ov_reg;
        cf_next       = cf_reg;
        tgt_next      = tgt_reg;
        nq_next       = nq_reg;
        bps_next      = bps_reg;
        qp0_next      = qp0_reg;
        fill_cnt_next = fill_cnt_reg;
        case (state_reg)
            sbqp_pkg::S_SB_UPD:
            begin
                if (win_sum[41:39] == 3'b000 || win_sum[41:39] == 3'b111)
                begin
                    window_next = win_sum[39:0];
                end
                else
                begin
                    window_next = win_sum[41] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
                end
                if (frm_sum[41:39] == 3'b000 || frm_sum[41:39] == 3'b111)
                begin
                    frame_next = frm_sum[39:0];
                end
                else
                begin
                    frame_next = frm_sum[41] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
                end
                if ((&ov_sum[57:47]) || !(|ov_sum[57:47]))
                begin
                    ov_next = ov_sum[47:0];
                end
                else
                begin
                    ov_next = ov_sum[57] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
                end
                tgt_next = (tgt_raw[42] || tgt_raw == '0) ? sbqp_pkg::TGT_W'(1) : tgt_raw[40:0];
            end
            sbqp_pkg::S_SB_DIV_WAIT:
            begin
                if (div_sts.done)
                begin
                    nq_next = (nq_hi < min_qp_reg) ? min_qp_reg : nq_hi;
                end
            end
            sbqp_pkg::S_FE_LVL:
            begin
                if (lvl[34])
                begin
                    buf_next = '0;
                end
                else if (lvl[33:32] != 2'd0)
                begin
                    buf_next = '1;
                end
                else
                begin
                    buf_next = lvl[31:0];
                end
                window_next = frame_reg;
                frame_next  = '0;
            end
            sbqp_pkg::S_FE_CF_GO:
            begin
                ov_next = {{6{buf_diff[33]}}, buf_diff, 8'd0};
            end
            sbqp_pkg::S_FE_CF_WAIT:
            begin
                if (div_sts.done)
                begin
                    cf_next = div_quo[sbqp_pkg::CF_W-1:0];
                end
            end
            sbqp_pkg::S_ST_BPS_WAIT:
            begin
                if (div_sts.done)
                begin
                    bps_next = div_quo[TB_W-1:0];
                end
            end
            sbqp_pkg::S_ST_STEP_WAIT:
            begin
                if (div_sts.done)
                begin
                    qp0_next = sbqp_pkg::qp_cap(st_qp_floor);
                end
            end
            sbqp_pkg::S_ST_INIT:
            begin
                window_next   = {8'd0, 32'(target_reg * sbqp_pkg::STEP_OF_QP[qp0_reg])};
                buf_next      = 32'(target_reg);
                init_next     = target_reg;
                ov_next       = '0;
                cf_next       = sbqp_pkg::CF_RESET;
                frame_next    = '0;
                fill_cnt_next = '0;
            end
            sbqp_pkg::S_ST_FILL:
            begin
                if (fill_more)
                begin
                    fill_cnt_next = fill_cnt_reg + 1'b1;
                end
            end
            default:
            begin
                nq_next = nq_reg;
            end
        endcase
    end

    // Control and rate state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= sbqp_pkg::S_IDLE;
            window_reg       <= '0;
            frame_reg        <= '0;
            buf_reg          <= '0;
            init_reg         <= '0;
            ov_reg           <= '0;
            cf_reg           <= sbqp_pkg::CF_RESET;
            fill_cnt_reg     <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            window_reg   <= window_next;
            frame_reg    <= frame_next;
            buf_reg      <= buf_next;
            init_reg     <= init_next;
            ov_reg       <= ov_next;
            cf_reg       <= cf_next;
            fill_cnt_reg <= fill_cnt_next;
            if (out_load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: item fields, products and per-item intermediates.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            addr_reg  <= idx_ext[SB_AW-1:0];
            bits_reg  <= sb_bits;
            qp_reg    <= sbqp_pkg::qp_cap(sb_qp);
            fbits_reg <= frame_bits;
        end
        if (state_reg == sbqp_pkg::S_SB_RD)
        begin
            cur_reg  <= 28'(bits_reg * sbqp_pkg::STEP_OF_QP[qp_reg]);
            last_reg <= 32'(rd_bits * sbqp_pkg::STEP_OF_QP[rd_qp]);
            cfp_reg  <= 56'(cf_reg * rd_bits);
        end
        tgt_reg <= tgt_next;
        nq_reg  <= nq_next;
        bps_reg <= bps_next;
        qp0_reg <= qp0_next;
        if (out_load)
        begin
            next_qp_reg <= nq_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign next_qp      = next_qp_reg;

    // History store, read at the incoming index so the entry is ready in the cycle after acceptance.
    sbqp_mem #(
        .DEPTH (MAX_SUPERBLOCKS),
        .AW    (SB_AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (idx_ext[SB_AW-1:0]),
        .rdata (mem_rdata)
    );

    // Divider shared by the step size, correction factor and start estimates.
    sbqp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .sts   (div_sts),
        .quo   (div_quo)
    );

endmodule

`default_nettype wire

@@ rtl/sbqp_chk.sv @@
// Port checker for the superblock QP rate controller, bound to the top level.
// Uses the macros of superblock_qp_rate_control_assert.svh and codes of sbqp_pkg.
`default_nettype none

`include "superblock_qp_rate_control_assert.svh"

module sbqp_chk #(
    parameter int MAX_SUPERBLOCKS = sbqp_pkg::MAX_SUPERBLOCKS_DEF
) (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            item_valid,
    input wire logic                            item_stall,
    input wire logic [sbqp_pkg::FUNC_W-1:0]     func,
    input wire logic [sbqp_pkg::IDX_W-1:0]      sb_index,
    input wire logic                            result_valid,
    input wire logic                            result_stall,
    input wire logic [sbqp_pkg::QP_W-1:0]       next_qp
);

    // A stalled QP beat stays offered and unchanged.
    `SBQP_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(next_qp))

    // A superblock beat that hits the store keeps the block busy in the next cycle.
    `SBQP_ASSERT_NEXT(a_sb_busy, item_valid && !item_stall && func == sbqp_pkg::FUNC_SB && 32'(sb_index) < 32'(MAX_SUPERBLOCKS), item_stall)

    // A start beat keeps the block busy while the estimates are worked out.
    `SBQP_ASSERT_NEXT(a_start_busy, item_valid && !item_stall && func == sbqp_pkg::FUNC_START, item_stall)

endmodule

bind superblock_qp_rate_control sbqp_chk #(
    .MAX_SUPERBLOCKS (MAX_SUPERBLOCKS)
) u_sbqp_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .func         (func),
    .sb_index     (sb_index),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .next_qp      (next_qp)
);

`default_nettype wire

@@ sim/sbqp_checker.sv @@
`timescale 1ns / 100ps
// Checker for the superblock QP rate controller: watches the config port and both channels.
// Predicts each next_qp beat with its own rate control model; uses sbqp_pkg for widths and tables.

module sbqp_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [sbqp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [sbqp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                            item_valid,
    input  wire logic                            item_stall,
    input  wire logic [sbqp_pkg::FUNC_W-1:0]     func,
    input  wire logic [sbqp_pkg::IDX_W-1:0]      sb_index,
    input  wire logic [sbqp_pkg::BITS_W-1:0]     sb_bits,
    input  wire logic [sbqp_pkg::QP_W-1:0]       sb_qp,
    input  wire logic [sbqp_pkg::FBITS_W-1:0]    frame_bits,
    input  wire logic                            result_valid,
    input  wire logic                            result_stall,
    input  wire logic [sbqp_pkg::QP_W-1:0]       next_qp,
    output int                                   fail_count,
    output int                                   pending
);
    import sbqp_pkg::*;

    localparam int     HIST_DEPTH = 4096;
    localparam longint W40_HI     = 64'sd549755813887;
    localparam longint W40_LO     = -W40_HI - 1;
    localparam longint W48_HI     = 64'sd140737488355327;
    localparam longint W48_LO     = -W48_HI - 1;
    localparam longint BUF_HI     = 64'sd4294967295;

    // Register shadows.
    logic [TB_W-1:0]  rc_target;
    logic [NSB_W-1:0] rc_nsb;
    logic [QP_W-1:0]  rc_min_qp;
    logic [QP_W-1:0]  rc_max_qp;
    logic [QP_W-1:0]  rc_floor_qp;

    // Rate control state.
    logic [EBITS_W-1:0] hist_bits [HIST_DEPTH];
    logic [QP_W-1:0]    hist_qp [HIST_DEPTH];
    longint             window_acc;
    longint             frame_acc;
    longint             vbuf_level;
    longint             vbuf_start;
    longint             overprod;
    logic [CF_W-1:0]    rate_gain;

    logic [QP_W-1:0] expected_qp_q [$];
    int              mismatches;

    assign fail_count = mismatches;
    assign pending    = expected_qp_q.size();

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic logic [QP_W-1:0] top_qp(input logic [QP_W-1:0] q);
        return (q > QP_W'(TOP_QP)) ? QP_W'(TOP_QP) : q;
    endfunction

    // Sequence start: seed the history with the per-superblock estimate.
    task automatic start_sequence();
        longint          nsb;
        longint          bps;
        longint          step;
        longint          fill;
        logic [QP_W-1:0] q;
        nsb  = (rc_nsb == 0) ? 1 : rc_nsb;
        bps  = rc_target / nsb;
        step = 2048 / ((bps == 0) ? 1 : bps);
        if (step > MAX_STEP)
        begin
            step = MAX_STEP;
        end
        q = QP_OF_STEP[step];
        if (rc_floor_qp > q)
        begin
            q = rc_floor_qp;
        end
        q    = top_qp(q);
        fill = (rc_nsb < HIST_DEPTH) ? rc_nsb : HIST_DEPTH;
        for (int i = 0; i < fill; i++)
        begin
            hist_bits[i] = EBITS_W'(bps);
            hist_qp[i]   = q;
        end
        window_acc  = longint'(rc_target) * STEP_OF_QP[q];
        vbuf_level  = rc_target;
        vbuf_start  = rc_target;
        overprod    = 0;
        rate_gain   = CF_RESET;
        frame_acc   = 0;
    endtask

    // Frame end: virtual buffer, overproduction and correction factor.
    task automatic end_frame(input logic [FBITS_W-1:0] fbits);
        longint         lvl;
        logic [63:0]    num;
        lvl        = vbuf_level + longint'(fbits) - longint'(rc_target);
        vbuf_level = clamp(lvl, 0, BUF_HI);
        overprod   = clamp((vbuf_level - vbuf_start) * 256, W48_LO, W48_HI);
        if (fbits != 0)
        begin
            num       = (64'(rc_target) << 8) + 64'(fbits >> 1);
            rate_gain = CF_W'(num / 64'(fbits));
        end
        window_acc = frame_acc;
        frame_acc  = 0;
    endtask

    // Superblock done: update the window and work out the next QP.
    function automatic logic [QP_W-1:0] next_superblock_qp(input logic [IDX_W-1:0] idx,
                                                           input logic [BITS_W-1:0] bits,
                                                           input logic [QP_W-1:0] qp_raw);
        logic [QP_W-1:0] qp;
        logic [QP_W-1:0] old_qp;
        logic [QP_W-1:0] nq;
        longint          old_bits;
        longint          cur;
        longint          old;
        longint          x;
        longint          shifted;
        longint          tgt;
        longint          num;
        longint          step;
        qp       = top_qp(qp_raw);
        old_bits = hist_bits[idx];
        old_qp   = top_qp(hist_qp[idx]);
        cur      = longint'(bits) * STEP_OF_QP[qp];
        old      = old_bits * STEP_OF_QP[old_qp];
        hist_bits[idx] = EBITS_W'(bits);
        hist_qp[idx]   = qp;
        window_acc = clamp(window_acc + cur - old, W40_LO, W40_HI);
        frame_acc  = clamp(frame_acc + cur, W40_LO, W40_HI);
        // Floor division of the overproduction, rounded.
        x       = overprod + 128;
        shifted = (x >= 0) ? x / 256 : -((-x + 255) / 256);
        tgt     = longint'(rc_target) - shifted;
        if (tgt <= 0)
        begin
            tgt = 1;
        end
        num  = window_acc + tgt / 2;
        step = (num <= 0) ? 0 : num / tgt;
        if (step < 1)
        begin
            step = 1;
        end
        if (step > MAX_STEP)
        begin
            step = MAX_STEP;
        end
        nq = QP_OF_STEP[step];
        if (nq > rc_max_qp)
        begin
            nq = rc_max_qp;
        end
        if (nq < rc_min_qp)
        begin
            nq = rc_min_qp;
        end
        overprod = clamp(overprod + longint'(bits) * 256 - longint'(rate_gain) * old_bits,
                         W48_LO, W48_HI);
        return nq;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rc_target   <= 24'd100000;
            rc_nsb      <= 13'd1;
            rc_min_qp   <= '0;
            rc_max_qp   <= QP_W'(TOP_QP);
            rc_floor_qp <= '0;
            window_acc  = 0;
            frame_acc   = 0;
            vbuf_level  = 0;
            vbuf_start  = 0;
            overprod    = 0;
            rate_gain   = CF_RESET;
            mismatches  = 0;
            expected_qp_q.delete();
        end
        else
        begin
            // Result beats are checked before this edge's item is predicted.
            if (result_valid && !result_stall)
            begin
                if (expected_qp_q.size() == 0)
                begin
                    if (mismatches < 10)
                    begin
                        $display("ERROR: unexpected next_qp beat %0d", next_qp);
                    end
                    mismatches++;
                end
                else
                begin
                    if (next_qp !== expected_qp_q[0])
                    begin
                        if (mismatches < 10)
                        begin
                            $display("ERROR: next_qp expected %0d actual %0d",
                                     expected_qp_q[0], next_qp);
                        end
                        mismatches++;
                    end
                    void'(expected_qp_q.pop_front());
                end
            end

            if (item_valid && !item_stall)
            begin
                if (func == FUNC_START)
                begin
                    start_sequence();
                end
                else if (func == FUNC_FRAME_END)
                begin
                    end_frame(frame_bits);
                end
                else if (func == FUNC_SB)
                begin
                    expected_qp_q.push_back(next_superblock_qp(sb_index, sb_bits, sb_qp));
                end
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TARGET_BITS:     rc_target   <= cfg_data[TB_W-1:0];
                    CFG_NUM_SUPERBLOCKS: rc_nsb      <= cfg_data[NSB_W-1:0];
                    CFG_MIN_QP:          rc_min_qp   <= cfg_data[QP_W-1:0];
                    CFG_MAX_QP:          rc_max_qp   <= cfg_data[QP_W-1:0];
                    CFG_INTRA_FLOOR_QP:  rc_floor_qp <= cfg_data[QP_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

@@ sim/superblock_qp_rate_control_tb.sv @@
`timescale 1ns / 100ps
// Testbench top for the superblock QP rate controller: clock, reset, stimulus and verdict.
// Instantiates superblock_qp_rate_control and sbqp_checker; uses sbqp_pkg.

module superblock_qp_rate_control_tb;
    import sbqp_pkg::*;

    localparam int SETTLE_CYCLES = 4400;

    // Function code that the block ignores.
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  item_valid;
    logic                  item_stall;
    logic [FUNC_W-1:0]     func;
    logic [IDX_W-1:0]      sb_index;
    logic [BITS_W-1:0]     sb_bits;
    logic [QP_W-1:0]       sb_qp;
    logic [FBITS_W-1:0]    frame_bits;
    logic                  result_valid;
    logic                  result_stall;
    logic [QP_W-1:0]       next_qp;

    int fail_count;
    int pending;

    // Stimulus control.
    int          send_idle_pct = 26;
    int          recv_idle_pct = 74;
    int          beats_sent    = 0;
    logic        hold_off      = 1'b0;
    int unsigned cur_target;
    int unsigned cur_nsb;
    int unsigned cur_fill;

    superblock_qp_rate_control DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .item_valid(item_valid), .item_stall(item_stall),
        .func(func), .sb_index(sb_index), .sb_bits(sb_bits), .sb_qp(sb_qp),
        .frame_bits(frame_bits),
        .result_valid(result_valid), .result_stall(result_stall), .next_qp(next_qp)
    );

    sbqp_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .item_valid(item_valid), .item_stall(item_stall),
        .func(func), .sb_index(sb_index), .sb_bits(sb_bits), .sb_qp(sb_qp),
        .frame_bits(frame_bits),
        .result_valid(result_valid), .result_stall(result_stall), .next_qp(next_qp),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    initial
    begin
        #40000000;
        $display("FAIL superblock_qp_rate_control");
        $finish;
    end

    // Receiver side stalls.
    always @(posedge clk)
    begin
        result_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
    end

    // One long receiver hold-off while the sender keeps offering beats.
    initial
    begin
        wait (beats_sent >= 700);
        @(posedge clk);
        hold_off = 1'b1;
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
    end

    // Offer one item beat and wait until it is taken.
    task automatic send_item(input logic [FUNC_W-1:0] f, input logic [IDX_W-1:0] idx,
                             input logic [BITS_W-1:0] bits, input logic [QP_W-1:0] qp,
                             input logic [FBITS_W-1:0] fbits);
        if (beats_sent < 550)
        begin
            send_idle_pct = 26;
            recv_idle_pct = 74;
        end
        else if (beats_sent < 1100)
        begin
            send_idle_pct = 74;
            recv_idle_pct = 26;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        if ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
            begin
                @(posedge clk);
            end
        end
        item_valid <= 1'b1;
        func       <= f;
        sb_index   <= idx;
        sb_bits    <= bits;
        sb_qp      <= qp;
        frame_bits <= fbits;
        @(posedge clk);
        while (item_stall)
        begin
            @(posedge clk);
        end
        beats_sent++;
    endtask

    // Wait until every expected beat is in, then let a start or frame end finish.
    task automatic settle();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
    endtask

    task automatic configure(input int unsigned tgt, input int unsigned nsb,
                             input int unsigned lo_qp, input int unsigned hi_qp,
                             input int unsigned floor_qp);
        settle();
        write_reg(CFG_TARGET_BITS, CFG_DATA_W'(tgt));
        write_reg(CFG_NUM_SUPERBLOCKS, CFG_DATA_W'(nsb));
        write_reg(CFG_MIN_QP, CFG_DATA_W'(lo_qp));
        write_reg(CFG_MAX_QP, CFG_DATA_W'(hi_qp));
        write_reg(CFG_INTRA_FLOOR_QP, CFG_DATA_W'(floor_qp));
        cfg_we <= 1'b0;
        @(posedge clk);
        cur_target = tgt;
        cur_nsb    = nsb;
        cur_fill   = (nsb < 4096) ? nsb : 4096;
    endtask

    function automatic logic [BITS_W-1:0] pick_bits();
        logic [BITS_W-1:0] b;
        int unsigned       per_sb;
        per_sb = cur_target / cur_nsb;
        case ($urandom_range(4))
            0: b = BITS_W'($urandom_range(2000));
            1: b = BITS_W'($urandom);
            2: b = ($urandom_range(1) != 0) ? '1 : '0;
            default: b = BITS_W'((per_sb > 1048575) ? 1048575 :
                                 $urandom_range(per_sb + per_sb / 2, per_sb / 2));
        endcase
        return b;
    endfunction

    function automatic logic [FBITS_W-1:0] pick_frame_bits();
        logic [FBITS_W-1:0] fb;
        case ($urandom_range(7))
            0: fb = '0;
            1: fb = '1;
            2: fb = FBITS_W'($urandom);
            default: fb = FBITS_W'($urandom_range(cur_target + cur_target / 2, cur_target / 2));
        endcase
        return fb;
    endfunction

    function automatic logic [QP_W-1:0] pick_qp();
        return ($urandom_range(9) == 0) ? QP_W'($urandom_range(63, 52))
                                        : QP_W'($urandom_range(51));
    endfunction

    task automatic send_start();
        send_item(FUNC_START, IDX_W'($urandom), BITS_W'($urandom), QP_W'($urandom),
                  FBITS_W'($urandom));
    endtask

    task automatic send_sb(input int unsigned idx);
        send_item(FUNC_SB, IDX_W'(idx), pick_bits(), pick_qp(), FBITS_W'($urandom));
    endtask

    task automatic send_frame_end();
        send_item(FUNC_FRAME_END, IDX_W'($urandom), BITS_W'($urandom), QP_W'($urandom),
                  pick_frame_bits());
    endtask

    // Well-formed frames with random content, and some noise.
    task automatic run_phase(input int budget);
        int start_at;
        int frame_len;
        int pick;
        start_at = beats_sent;
        send_start();
        while (beats_sent - start_at < budget)
        begin
            frame_len = (cur_nsb <= 48) ? cur_nsb : $urandom_range(48, 8);
            for (int i = 0; i < frame_len; i++)
            begin
                pick = $urandom_range(99);
                if (pick < 3)
                begin
                    send_item(FUNC_UNUSED, IDX_W'($urandom), BITS_W'($urandom),
                              QP_W'($urandom), FBITS_W'($urandom));
                end
                else if (pick < 5)
                begin
                    send_frame_end();
                end
                else if (pick < 6)
                begin
                    send_start();
                end
                else if (pick < 25)
                begin
                    send_sb($urandom_range(cur_fill - 1));
                end
                else
                begin
                    send_sb(i % cur_fill);
                end
            end
            send_frame_end();
            // Sender pause until the block has delivered everything.
            if (beats_sent >= 1000 && beats_sent - frame_len < 1000)
            begin
                item_valid <= 1'b0;
                @(posedge clk);
                while (pending != 0)
                begin
                    @(posedge clk);
                end
            end
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        item_valid   = 1'b0;
        func         = FUNC_SB;
        sb_index     = '0;
        sb_bits      = '0;
        sb_qp        = '0;
        frame_bits   = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, unused code, zero and full frame bits, tiny target.
        configure(1000, 4, 0, 51, 0);
        send_start();
        send_item(FUNC_SB, IDX_W'(0), '0, 6'd0, '0);
        send_item(FUNC_SB, IDX_W'(1), '1, 6'd51, '0);
        send_item(FUNC_SB, IDX_W'(2), '1, 6'd63, '0);
        send_item(FUNC_SB, IDX_W'(3), 20'd12345, 6'd30, '0);
        send_item(FUNC_UNUSED, '1, '1, '1, '1);
        send_item(FUNC_FRAME_END, IDX_W'(0), BITS_W'(0), QP_W'(0), '0);
        send_item(FUNC_SB, IDX_W'(0), '1, 6'd51, '0);
        send_item(FUNC_FRAME_END, IDX_W'(0), BITS_W'(0), QP_W'(0), '1);
        for (int i = 0; i < 4; i++)
        begin
            send_item(FUNC_SB, IDX_W'(i), '1, 6'd51, '0);
        end
        send_item(FUNC_FRAME_END, IDX_W'(0), BITS_W'(0), QP_W'(0), 28'd1000);
        send_item(FUNC_SB, IDX_W'(1), 20'd7, 6'd4, '0);
        send_start();
        send_item(FUNC_SB, IDX_W'(2), 20'd500, 6'd20, '0);

        configure(1, 1, 0, 0, 0);
        send_start();
        send_item(FUNC_SB, IDX_W'(0), '1, 6'd51, '0);
        send_item(FUNC_SB, IDX_W'(0), '0, 6'd0, '0);
        send_item(FUNC_FRAME_END, IDX_W'(0), BITS_W'(0), QP_W'(0), '1);
        send_item(FUNC_SB, IDX_W'(0), 20'd3, 6'd10, '0);

        // Random phases across register settings, extremes among them.
        configure(100000, 16, 0, 51, 0);
        run_phase(220);
        configure(16777215, 1, 0, 51, 51);
        run_phase(160);
        configure(1, 4096, 51, 0, 0);
        run_phase(180);
        configure(5000, 64, 10, 40, 20);
        run_phase(220);
        configure(300000, 32, 20, 30, 35);
        run_phase(220);
        configure(16777215, 4096, 0, 51, 51);
        run_phase(180);
        configure(2000, 3, 0, 51, 0);
        run_phase(200);
        configure(800000, 200, 5, 45, 12);
        run_phase(220);

        // Drain and let the last item finish.
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
        begin
            $display("PASS superblock_qp_rate_control");
        end
        else
        begin
            $display("FAIL superblock_qp_rate_control");
        end
        $finish;
    end

endmodule
